// File: rtl/core/utfh_pkg.sv
`default_nettype none

package utfh_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [7:0] BYTE_TERM = 8'h00;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;
  localparam logic [1:0] SKIP_LEAD3 = 2'd2;
  localparam logic [1:0] SKIP_LEAD4 = 2'd3;
  localparam logic [7:0] CHAR_NONE = 8'h00;

  typedef struct packed {
    logic        word_valid;
    logic [31:0] hash;
    logic        is_number;
    logic [15:0] index;
    logic        text_end;
  } utfh_word_t;

  function automatic logic [7:0] fold_ascii(input logic [7:0] c);
    logic [7:0] r;
    begin
      case (c) inside
        [8'h41:8'h5A]: r = c + 8'd32;
        [8'h61:8'h7A], [8'h30:8'h39]: r = c;
        default: r = CHAR_NONE;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] fold_latin(input logic [10:0] cp);
    logic [7:0] r;
    begin
      case (cp) inside
        [11'h0C0:11'h0C5], [11'h0E0:11'h0E5]: r = 8'h61;
        [11'h0C8:11'h0CB], [11'h0E8:11'h0EB]: r = 8'h65;
        [11'h0CC:11'h0CF], [11'h0EC:11'h0EF]: r = 8'h69;
        [11'h0D2:11'h0D6], [11'h0F2:11'h0F6]: r = 8'h6F;
        [11'h0D9:11'h0DC], [11'h0F9:11'h0FC]: r = 8'h75;
        11'h0C7, 11'h0E7: r = 8'h63;
        11'h0D1, 11'h0F1: r = 8'h6E;
        default: r = CHAR_NONE;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/utf8_fold_word_hasher.sv
// Splits a UTF-8 byte stream into words and gives one transaction per finished word
// and one per terminator byte, which also carries any word that it finishes, with a
// 32-bit FNV-1a word hash reduced modulo ID_SPAN plus id_base. The block takes one byte
// every clock cycle while in_stall is low, because the running hash update is a single
// 32-bit multiply by the FNV prime. A result goes from the input register, where the
// tokenizer state updates, through three reduction stages whose two constant multiplies
// and correcting subtract compute the remainder, into the output register.
// Write id_base only while the block is idle.
`default_nettype none

module utf8_fold_word_hasher import utfh_pkg::*; #(
  parameter int unsigned WORD_MAX_CHARS = 32,
  parameter logic [31:0] ID_SPAN        = 32'd65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_id_base,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             word_valid,
  output logic [31:0]      word_id,
  output logic             word_is_number,
  output logic [15:0]      word_index,
  output logic             text_end
);

  logic        id_valid_w;
  utfh_word_t  id_word;
  logic        id_ready;
  logic [31:0] id_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      id_base <= cfg_id_base;
    end
  end

  utfh_tokenizer #(
    .WORD_MAX_CHARS(WORD_MAX_CHARS)
  ) u_tokenizer (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .res_valid(id_valid_w),
    .res(id_word),
    .res_ready(id_ready)
  );

  utfh_reduce #(
    .ID_SPAN(ID_SPAN)
  ) u_reduce (
    .clk(clk),
    .rst(rst),
    .res_valid(id_valid_w),
    .res(id_word),
    .res_ready(id_ready),
    .id_base(id_base),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word_valid(word_valid),
    .word_id(word_id),
    .word_is_number(word_is_number),
    .word_index(word_index),
    .text_end(text_end)
  );

endmodule

`default_nettype wire

// File: rtl/core/utfh_tokenizer.sv
`default_nettype none

module utfh_tokenizer import utfh_pkg::*; #(
  parameter int unsigned WORD_MAX_CHARS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_byte,
  output logic            res_valid,
  output utfh_word_t      res,
  input  wire logic       res_ready
);

  localparam int LEN_W = $clog2(WORD_MAX_CHARS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_MAX_CHARS);

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic             take;

  logic [31:0]      running_hash;
  logic [LEN_W-1:0] kept_length;
  logic             digits_only;
  logic             lead_pending;
  logic [4:0]       lead_bits;
  logic [1:0]       skip_count;
  logic [15:0]      word_counter;

  logic [31:0]      running_hash_next;
  logic [LEN_W-1:0] kept_length_next;
  logic             digits_only_next;
  logic             lead_pending_next;
  logic [4:0]       lead_bits_next;
  logic [1:0]       skip_count_next;
  logic [15:0]      word_counter_next;

  logic             char_take;
  logic [7:0]       ch;
  logic             produce;
  logic [31:0]      hash_mul;
  logic             word_open;

  assign word_open = (kept_length != '0);
  assign hash_mul  = (running_hash ^ {24'd0, ch}) * FNV_PRIME;

  always_comb begin
    running_hash_next = running_hash;
    kept_length_next  = kept_length;
    digits_only_next  = digits_only;
    lead_pending_next = lead_pending;
    lead_bits_next    = lead_bits;
    skip_count_next   = skip_count;
    word_counter_next = word_counter;
    char_take         = 1'b0;
    ch                = CHAR_NONE;
    produce           = 1'b0;
    res               = '0;

    if (byte_q == BYTE_TERM) begin
      produce = 1'b1;
      res.text_end = 1'b1;
      if (word_open) begin
        res.word_valid = 1'b1;
        res.hash       = running_hash;
        res.is_number  = digits_only;
        res.index      = word_counter;
      end
      running_hash_next = FNV_BASIS;
      kept_length_next  = '0;
      digits_only_next  = 1'b1;
      lead_pending_next = 1'b0;
      lead_bits_next    = '0;
      skip_count_next   = '0;
      word_counter_next = '0;
    end else if (lead_pending) begin
      lead_pending_next = 1'b0;
      char_take = 1'b1;
      ch = fold_latin({lead_bits, byte_q[5:0]});
    end else if (skip_count != '0) begin
      skip_count_next = skip_count - 2'd1;
    end else if (!byte_q[7]) begin
      char_take = 1'b1;
      ch = fold_ascii(byte_q);
    end else if ((byte_q & MASK_LEAD2) == CODE_LEAD2) begin
      lead_pending_next = 1'b1;
      lead_bits_next    = byte_q[4:0];
    end else begin
      char_take = 1'b1;
      if ((byte_q & MASK_LEAD3) == CODE_LEAD3) begin
        skip_count_next = SKIP_LEAD3;
      end else if ((byte_q & MASK_LEAD4) == CODE_LEAD4) begin
        skip_count_next = SKIP_LEAD4;
      end
    end

    if (char_take) begin
      if (ch == CHAR_NONE) begin
        if (word_open) begin
          produce = 1'b1;
          res.word_valid = 1'b1;
          res.hash       = running_hash;
          res.is_number  = digits_only;
          res.index      = word_counter;
          if (word_counter != 16'hFFFF) begin
            word_counter_next = word_counter + 16'd1;
          end
          running_hash_next = FNV_BASIS;
          kept_length_next  = '0;
          digits_only_next  = 1'b1;
        end
      end else if (kept_length < LEN_MAX) begin
        running_hash_next = hash_mul;
        kept_length_next  = kept_length + LEN_W'(1);
        if (ch < 8'h30 || ch > 8'h39) begin
          digits_only_next = 1'b0;
        end
      end
    end
  end

  assign res_valid = byte_valid && produce;
  assign take      = byte_valid && (!produce || res_ready);
  assign in_stall  = byte_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_q <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
      kept_length  <= '0;
      digits_only  <= 1'b1;
      lead_pending <= 1'b0;
      lead_bits    <= '0;
      skip_count   <= '0;
      word_counter <= '0;
    end else if (take) begin
      running_hash <= running_hash_next;
      kept_length  <= kept_length_next;
      digits_only  <= digits_only_next;
      lead_pending <= lead_pending_next;
      lead_bits    <= lead_bits_next;
      skip_count   <= skip_count_next;
      word_counter <= word_counter_next;
    end
  end

  a_lead_skip_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(lead_pending && skip_count != '0))
    else $error("Lead byte pending while continuation bytes are being skipped.");

  a_len_bounded: assert property (@(posedge clk) disable iff (rst)
    kept_length <= LEN_MAX)
    else $error("Kept word length exceeds the character limit.");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    take && byte_q == BYTE_TERM |=> kept_length == '0 && word_counter == '0
      && !lead_pending && skip_count == '0)
    else $error("Terminator did not return the text state to its start.");

endmodule

`default_nettype wire

// File: rtl/core/utfh_reduce.sv
`default_nettype none

module utfh_reduce import utfh_pkg::*; #(
  parameter logic [31:0] ID_SPAN = 32'd65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_valid,
  input  wire utfh_word_t  res,
  output logic             res_ready,
  input  wire logic [31:0] id_base,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             word_valid,
  output logic [31:0]      word_id,
  output logic             word_is_number,
  output logic [15:0]      word_index,
  output logic             text_end
);

  localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / {32'd0, ID_SPAN};
  localparam logic [31:0] RECIP = RECIP_FULL[31:0];

  logic        va, vb, vc;
  utfh_word_t  wa, wb, wc;
  logic [63:0] prod_a;
  logic [31:0] qs_b;
  logic [31:0] red_c;
  logic        rdy_a, rdy_b, rdy_c, rdy_d;

  logic [31:0] r_raw;
  logic [32:0] r_sub;
  logic [31:0] r_fix;

  assign rdy_d     = !out_valid || !out_stall;
  assign rdy_c     = !vc || rdy_d;
  assign rdy_b     = !vb || rdy_c;
  assign rdy_a     = !va || rdy_b;
  assign res_ready = rdy_a;

  assign r_raw = wb.hash - qs_b;
  assign r_sub = {1'b0, r_raw} - {1'b0, ID_SPAN};
  assign r_fix = (ID_SPAN == 32'd1) ? 32'd0 : (r_sub[32] ? r_raw : r_sub[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) begin
        va <= res_valid;
      end
      if (rdy_b) begin
        vb <= va;
      end
      if (rdy_c) begin
        vc <= vb;
      end
      if (rdy_d) begin
        out_valid <= vc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && res_valid) begin
      wa     <= res;
      prod_a <= {32'd0, res.hash} * {32'd0, RECIP};
    end
    if (rdy_b && va) begin
      wb   <= wa;
      qs_b <= prod_a[63:32] * ID_SPAN;
    end
    if (rdy_c && vb) begin
      wc    <= wb;
      red_c <= r_fix;
    end
    if (rdy_d && vc) begin
      word_valid     <= wc.word_valid;
      word_id        <= wc.word_valid ? id_base + red_c : 32'd0;
      word_is_number <= wc.is_number;
      word_index     <= wc.index;
      text_end       <= wc.text_end;
    end
  end

  a_estimate_low: assert property (@(posedge clk) disable iff (rst)
    vb |-> qs_b <= wb.hash)
    else $error("Quotient estimate overshoots the hash.");

  a_remainder_range: assert property (@(posedge clk) disable iff (rst)
    vb && ID_SPAN != 32'd1 |-> r_fix < ID_SPAN)
    else $error("Reduced hash is not below the span.");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !word_valid |-> word_id == 32'd0 && word_index == 16'd0
      && !word_is_number && text_end)
    else $error("A result without a word carries nonzero fields.");

endmodule

`default_nettype wire

// File: tb/utf8_fold_word_hasher_test.sv
`default_nettype none

module utf8_fold_word_hasher_test import utfh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_MAX_CHARS = 32;
  localparam logic [31:0] ID_SPAN = 32'd65536;
  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_REPORTS = 200;

  localparam logic [7:0] DIRECTED_TEXT [0:24] = '{
    8'h41, 8'h62, 8'h39, 8'h20, 8'hC3, 8'h89, 8'hC3, 8'h97, 8'h37, 8'hD0,
    8'h00, 8'hE2, 8'h82, 8'hAC, 8'h7A, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80,
    8'hFF, 8'hE5, 8'h41, 8'h00, 8'h00
  };

  typedef struct packed {
    logic        present;
    logic [31:0] id;
    logic        numeric;
    logic [15:0] index;
    logic        last;
  } word_result_t;

  class word_id_tracker #(int unsigned MAX_CHARS = 32, logic [31:0] SPAN = 32'd65536);
    logic [31:0] id_base;
    logic [31:0] hash;
    logic [7:0]  kept;
    logic        digits_only;
    logic        lead_pending;
    logic [4:0]  lead_bits;
    logic [1:0]  skip_left;
    logic [15:0] word_count;
    word_result_t pending_words[$];
    int unsigned mismatches;
    int unsigned words_seen;

    function new();
      id_base = '0;
      mismatches = 0;
      words_seen = 0;
      clear_text();
    endfunction

    function void clear_word();
      hash = FNV_BASIS;
      kept = '0;
      digits_only = 1'b1;
    endfunction

    function void clear_text();
      clear_word();
      lead_pending = 1'b0;
      lead_bits = '0;
      skip_left = '0;
      word_count = '0;
    endfunction

    function logic [7:0] fold_ascii_char(logic [7:0] b);
      if (b >= "A" && b <= "Z") return b + 8'd32;
      if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9")) return b;
      return CHAR_NONE;
    endfunction

    // Upper and lower case accented letters share the low five bits of the code point.
    function logic [7:0] fold_latin_char(logic [10:0] cp);
      if (cp[10:6] != 5'd3) return CHAR_NONE;
      case (cp[4:0])
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: return "a";
        5'd7: return "c";
        5'd8, 5'd9, 5'd10, 5'd11: return "e";
        5'd12, 5'd13, 5'd14, 5'd15: return "i";
        5'd17: return "n";
        5'd18, 5'd19, 5'd20, 5'd21, 5'd22: return "o";
        5'd25, 5'd26, 5'd27, 5'd28: return "u";
        default: return CHAR_NONE;
      endcase
    endfunction

    function bit close_word(output word_result_t r);
      logic [63:0] h;
      r = '0;
      if (kept == 0) return 1'b0;
      h = {32'd0, hash};
      if (SPAN != 0) h = h % SPAN;
      r.present = 1'b1;
      r.id = id_base + h[31:0];
      r.numeric = digits_only;
      r.index = word_count;
      if (word_count != 16'hFFFF) word_count++;
      clear_word();
      return 1'b1;
    endfunction

    function void take_byte(logic [7:0] b);
      word_result_t r;
      logic [7:0] ch;
      if (b == BYTE_TERM) begin
        void'(close_word(r));
        r.last = 1'b1;
        clear_text();
        pending_words.push_back(r);
        return;
      end
      if (lead_pending) begin
        lead_pending = 1'b0;
        ch = fold_latin_char({lead_bits, b[5:0]});
      end else if (skip_left != 0) begin
        skip_left--;
        return;
      end else if (b < 8'h80) begin
        ch = fold_ascii_char(b);
      end else begin
        ch = CHAR_NONE;
        if ((b & MASK_LEAD2) == CODE_LEAD2) begin
          lead_pending = 1'b1;
          lead_bits = b[4:0];
          return;
        end
        if ((b & MASK_LEAD3) == CODE_LEAD3) skip_left = SKIP_LEAD3;
        else if ((b & MASK_LEAD4) == CODE_LEAD4) skip_left = SKIP_LEAD4;
      end
      if (ch == CHAR_NONE) begin
        if (close_word(r)) pending_words.push_back(r);
      end else if (kept < MAX_CHARS) begin
        hash = (hash ^ {24'd0, ch}) * FNV_PRIME;
        kept++;
        if (ch < "0" || ch > "9") digits_only = 1'b0;
      end
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR: result %0d: %s", words_seen, msg);
    endfunction

    function void check_word(word_result_t got);
      word_result_t want;
      if (pending_words.size() == 0) begin
        flag_mismatch("output transaction with no byte waiting for it");
        words_seen++;
        return;
      end
      want = pending_words.pop_front();
      if (got.present !== want.present)
        flag_mismatch($sformatf("word_valid got %b want %b", got.present, want.present));
      if (got.id !== want.id)
        flag_mismatch($sformatf("word_id got %h want %h", got.id, want.id));
      if (got.numeric !== want.numeric)
        flag_mismatch($sformatf("word_is_number got %b want %b", got.numeric, want.numeric));
      if (got.index !== want.index)
        flag_mismatch($sformatf("word_index got %0d want %0d", got.index, want.index));
      if (got.last !== want.last)
        flag_mismatch($sformatf("text_end got %b want %b", got.last, want.last));
      words_seen++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_id_base = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        word_valid;
  logic [31:0] word_id;
  logic        word_is_number;
  logic [15:0] word_index;
  logic        text_end;

  word_id_tracker #(WORD_MAX_CHARS, ID_SPAN) tracker;
  bit          idle_on;
  int unsigned sent_count;
  int unsigned stall_left;
  int unsigned cycle_count;

  utf8_fold_word_hasher #(
    .WORD_MAX_CHARS(WORD_MAX_CHARS),
    .ID_SPAN(ID_SPAN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_id_base(cfg_id_base),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word_valid(word_valid),
    .word_id(word_id),
    .word_is_number(word_is_number),
    .word_index(word_index),
    .text_end(text_end)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Every accepted output transaction is checked against the oldest expected word.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        tracker.check_word({word_valid, word_id, word_is_number, word_index, text_end});
        stall_left = idle_on ? $urandom_range(0, 10) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_id_base(input logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_id_base <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.id_base = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input int unsigned len, input bit digits);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      if (digits) begin
        send_byte(8'("0" + $urandom_range(0, 9)));
      end else begin
        case ($urandom_range(0, 5))
          0: send_byte(8'("A" + $urandom_range(0, 25)));
          1, 2: send_byte(8'("a" + $urandom_range(0, 25)));
          3: send_byte(8'("0" + $urandom_range(0, 9)));
          4: begin
            send_byte(8'hC3);
            send_byte(8'(8'h80 + $urandom_range(0, 63)));
          end
          default: begin
            send_byte(8'(8'hC0 + $urandom_range(0, 31)));
            send_byte(8'($urandom_range(1, 255)));
          end
        endcase
      end
    end
  endtask

  task automatic send_token();
    int unsigned pick, n, k;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 8);
      send_word(n, 1'b0);
    end else if (pick < 42) begin
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
      send_word(n, 1'b1);
    end else if (pick < 62) begin
      do begin
        b = 8'($urandom_range(1, 127));
      end while ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"));
      send_byte(b);
    end else if (pick < 70) begin
      send_byte(8'(8'hE0 + $urandom_range(0, 15)));
      for (k = 0; k < 2; k++) send_byte(8'($urandom_range(1, 255)));
    end else if (pick < 76) begin
      send_byte(8'(8'hF0 + $urandom_range(0, 7)));
      for (k = 0; k < 3; k++) send_byte(8'($urandom_range(1, 255)));
    end else if (pick < 81) begin
      if ($urandom_range(0, 1) == 0) send_byte(8'(8'h80 + $urandom_range(0, 63)));
      else send_byte(8'(8'hF8 + $urandom_range(0, 7)));
    end else if (pick < 86) begin
      // A multi-byte sequence cut short by the end of the text.
      case ($urandom_range(0, 2))
        0: send_byte(8'(8'hC0 + $urandom_range(0, 31)));
        1: begin
          send_byte(8'(8'hE0 + $urandom_range(0, 15)));
          n = $urandom_range(0, 1);
          for (k = 0; k < n; k++) send_byte(8'($urandom_range(1, 255)));
        end
        default: begin
          send_byte(8'(8'hF0 + $urandom_range(0, 7)));
          n = $urandom_range(0, 2);
          for (k = 0; k < n; k++) send_byte(8'($urandom_range(1, 255)));
        end
      endcase
      send_byte(BYTE_TERM);
    end else if (pick < 93) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(BYTE_TERM);
    end
  endtask

  initial begin
    logic [31:0] phase_base [0:2];
    int unsigned p, start_count;
    tracker = new();
    idle_on = 1'b1;
    sent_count = 0;
    cycle_count = 0;
    phase_base = '{32'hFFFF_FFFF, $urandom, 32'hFFFF_8000};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    write_id_base(32'h0000_0000);
    foreach (DIRECTED_TEXT[k]) send_byte(DIRECTED_TEXT[k]);

    for (p = 0; p < 3; p++) begin
      write_id_base(phase_base[p]);
      start_count = sent_count;
      while (sent_count - start_count < RANDOM_ITEMS / 3) begin
        if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
        send_token();
      end
      send_byte(BYTE_TERM);
    end

    drain();
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/utfh_pkg.sv
rtl/core/utfh_tokenizer.sv
rtl/core/utfh_reduce.sv
rtl/core/utf8_fold_word_hasher.sv
tb/utf8_fold_word_hasher_test.sv
